// ===== design/etf_pkg.sv =====
// Shared types and constants for the escape-time fractal pixel block.
`timescale 1ns / 1ps
`default_nettype none

package etf_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_ITER  = 2'd0;
    localparam logic [1:0] CFG_JULIA     = 2'd1;
    localparam logic [1:0] CFG_JCONST_RE = 2'd2;
    localparam logic [1:0] CFG_JCONST_IM = 2'd3;

    // Fixed widths of the register file and the result fields
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int COORD_W       = 32;
    localparam int MAX_ITER_W    = 12;
    localparam int OUT_COUNT_W   = 12;
    localparam int CHAN_W        = 8;

    localparam logic [MAX_ITER_W-1:0] MAX_ITER_RESET = 12'd50;

    // Color table, packed as {red, green, blue}
    localparam logic [3*CHAN_W-1:0] PALETTE [16] = '{
        24'h42_1E_0F, 24'h19_07_1A, 24'h09_01_2F, 24'h04_04_49,
        24'h00_07_64, 24'h0C_2C_8A, 24'h18_52_B1, 24'h39_7D_D1,
        24'h86_B5_E5, 24'hD3_EC_F8, 24'hF1_E9_BF, 24'hF8_C9_5F,
        24'hFF_AA_00, 24'hCC_80_00, 24'h99_57_00, 24'h6A_34_03
    };

    // Command from the front end to the iteration engine
    typedef struct packed {
        logic start;
        logic julia;
    } etf_cmd_t;

    // Status from the iteration engine to the front end
    typedef struct packed {
        logic idle;
        logic done;
    } etf_sts_t;

endpackage

`default_nettype wire

// ===== design/escape_time_fractal_pixel.sv =====
// Top level of the escape-time fractal pixel block: registers, handshakes and coloring.
`timescale 1ns / 1ps
`default_nettype none

// Takes one complex point (signed 32-bit, FRACTION_BITS fraction bits) per transfer and returns
// its escape-time count and a palette color. Julia mode starts from the point with the
// configured constant; Mandelbrot mode starts from zero with the point as constant. Each
// update step runs through one shared 32x32 multiplier as three products and a write-back,
// and one point is in work at a time. A finished result sits in the output register, and the
// next point is taken while it waits. The user must write configuration through
// cfg_wr_en/cfg_index/cfg_wdata only while the block is idle; the block does not enforce it.
module escape_time_fractal_pixel #(
    parameter int COUNT_WIDTH   = 12,
    parameter int FRACTION_BITS = 27
) (
    input  wire                                       aclk,
    input  wire                                       aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [etf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [etf_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [etf_pkg::COORD_W-1:0]   s_point_re,
    input  wire logic signed [etf_pkg::COORD_W-1:0]   s_point_im,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [etf_pkg::OUT_COUNT_W-1:0]           m_iteration_count,
    output logic [etf_pkg::CHAN_W-1:0]                m_red,
    output logic [etf_pkg::CHAN_W-1:0]                m_green,
    output logic [etf_pkg::CHAN_W-1:0]                m_blue
);
    import etf_pkg::*;

    localparam int MAX_W = (COUNT_WIDTH < MAX_ITER_W) ? COUNT_WIDTH : MAX_ITER_W;

    logic [MAX_W-1:0]           max_iter_reg;
    logic                       julia_reg;
    logic signed [COORD_W-1:0]  jconst_re_reg, jconst_im_reg;

    logic                       m_valid_reg;
    logic [OUT_COUNT_W-1:0]     count_out_reg;
    logic [CHAN_W-1:0]          red_reg, green_reg, blue_reg;

    etf_cmd_t                   cmd;
    etf_sts_t                   sts;
    logic                       unload;
    logic [COUNT_WIDTH-1:0]     eng_count;
    logic [COUNT_WIDTH+OUT_COUNT_W-1:0] count_wide;
    logic [3*CHAN_W-1:0]        color;

    // Configuration register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg  <= MAX_ITER_RESET[MAX_W-1:0];
            julia_reg     <= 1'b0;
            jconst_re_reg <= '0;
            jconst_im_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MAX_ITER:  max_iter_reg  <= cfg_wdata[MAX_W-1:0];
                CFG_JULIA:     julia_reg     <= cfg_wdata[0];
                CFG_JCONST_RE: jconst_re_reg <= cfg_wdata;
                CFG_JCONST_IM: jconst_im_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Start the engine on an input transfer
    assign s_ready   = sts.idle;
    assign cmd.start = s_valid && sts.idle;
    assign cmd.julia = julia_reg;
    assign unload    = !m_valid_reg || m_ready;

    etf_iter #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .FRACTION_BITS (FRACTION_BITS),
        .MAX_W         (MAX_W)
    ) u_iter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .unload    (unload),
        .point_re  (s_point_re),
        .point_im  (s_point_im),
        .jconst_re (jconst_re_reg),
        .jconst_im (jconst_im_reg),
        .max_iter  (max_iter_reg),
        .sts       (sts),
        .count     (eng_count)
    );

    // Map the count to a color; entry zero is black in Julia mode
    assign count_wide = {{OUT_COUNT_W{1'b0}}, eng_count};
    always_comb begin
        if ((eng_count[3:0] == 4'd0) && julia_reg) begin
            color = '0;
        end else begin
            color = PALETTE[eng_count[3:0]];
        end
    end

    // Output register: hold until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (sts.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (sts.done) begin
            count_out_reg <= count_wide[OUT_COUNT_W-1:0];
            red_reg       <= color[3*CHAN_W-1:2*CHAN_W];
            green_reg     <= color[2*CHAN_W-1:CHAN_W];
            blue_reg      <= color[CHAN_W-1:0];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_iteration_count = count_out_reg;
    assign m_red             = red_reg;
    assign m_green           = green_reg;
    assign m_blue            = blue_reg;

endmodule

`default_nettype wire

// ===== design/etf_iter.sv =====
// Iteration engine: one shared multiplier sequenced over z = z^2 + c with a box escape test.
`timescale 1ns / 1ps
`default_nettype none

module etf_iter #(
    parameter int COUNT_WIDTH   = 12,
    parameter int FRACTION_BITS = 27,
    parameter int MAX_W         = 12
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire etf_pkg::etf_cmd_t           cmd,
    input  wire logic                        unload,
    input  wire logic signed [31:0]          point_re,
    input  wire logic signed [31:0]          point_im,
    input  wire logic signed [31:0]          jconst_re,
    input  wire logic signed [31:0]          jconst_im,
    input  wire logic [MAX_W-1:0]            max_iter,
    output etf_pkg::etf_sts_t                sts,
    output logic [COUNT_WIDTH-1:0]           count
);
    import etf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_CROSS,
        ST_UPDATE,
        ST_DONE
    } state_t;

    localparam int PROD_W = 2 * COORD_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic signed [PROD_W-1:0] BOX_LIMIT = 64'sd2 <<< FRACTION_BITS;
    localparam logic signed [SUM_W-1:0]  SAT_MAX   = 66'sd2147483647;
    localparam logic signed [SUM_W-1:0]  SAT_MIN   = -66'sd2147483648;

    state_t                     state_reg;
    logic                       first_reg;
    logic [COUNT_WIDTH-1:0]     count_reg;

    logic signed [COORD_W-1:0]  zr_reg, zi_reg, cr_reg, ci_reg;
    logic signed [PROD_W-1:0]   rr_reg, ii_reg, ri_reg;

    logic signed [COORD_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [PROD_W-1:0]   rr_sh, ii_sh, ri_sh;
    logic signed [SUM_W-1:0]    sum_re, sum_im;
    logic signed [PROD_W-1:0]   zr_wide, zi_wide;
    logic                       in_box;
    logic                       below_max;

    // Clamp a wide sum to the signed coordinate range
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] x);
        logic signed [COORD_W-1:0] r;
        if (x > SAT_MAX) begin
            r = SAT_MAX[COORD_W-1:0];
        end else if (x < SAT_MIN) begin
            r = SAT_MIN[COORD_W-1:0];
        end else begin
            r = x[COORD_W-1:0];
        end
        return r;
    endfunction

    // Select multiplier operands: zr*zr, then zi*zi, then zr*zi
    always_comb begin
        mul_a = (state_reg == ST_SQ_IM) ? zi_reg : zr_reg;
        mul_b = (state_reg == ST_SQ_RE) ? zr_reg : zi_reg;
    end
    assign mul_p = mul_a * mul_b;

    // Scale products (arithmetic shift rounds toward minus infinity) and sum
    assign rr_sh  = rr_reg >>> FRACTION_BITS;
    assign ii_sh  = ii_reg >>> FRACTION_BITS;
    assign ri_sh  = ri_reg >>> (FRACTION_BITS - 1);
    assign sum_re = SUM_W'(rr_sh) - SUM_W'(ii_sh) + SUM_W'(cr_reg);
    assign sum_im = SUM_W'(ri_sh) + SUM_W'(ci_reg);

    // Box escape test on the current z and iteration limit
    assign zr_wide   = PROD_W'(zr_reg);
    assign zi_wide   = PROD_W'(zi_reg);
    assign in_box    = (zr_wide <= BOX_LIMIT) && (zr_wide >= -BOX_LIMIT) &&
                       (zi_wide <= BOX_LIMIT) && (zi_wide >= -BOX_LIMIT);
    assign below_max = count_reg < COUNT_WIDTH'(max_iter);

    // Sequencer: state, first-pass flag and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd.start) begin
                        first_reg <= 1'b1;
                        count_reg <= '0;
                        state_reg <= ST_SQ_RE;
                    end
                end
                ST_SQ_RE: begin
                    if (first_reg) begin
                        first_reg <= 1'b0;
                        state_reg <= ST_SQ_IM;
                    end else if (in_box && below_max) begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= ST_SQ_IM;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_SQ_IM:  state_reg <= ST_CROSS;
                ST_CROSS:  state_reg <= ST_UPDATE;
                ST_UPDATE: state_reg <= ST_SQ_RE;
                ST_DONE: begin
                    if (unload) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath: load operands, capture products, write back z
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    zr_reg <= cmd.julia ? point_re : '0;
                    zi_reg <= cmd.julia ? point_im : '0;
                    cr_reg <= cmd.julia ? jconst_re : point_re;
                    ci_reg <= cmd.julia ? jconst_im : point_im;
                end
            end
            ST_SQ_RE: rr_reg <= mul_p;
            ST_SQ_IM: ii_reg <= mul_p;
            ST_CROSS: ri_reg <= mul_p;
            ST_UPDATE: begin
                zr_reg <= sat_coord(sum_re);
                zi_reg <= sat_coord(sum_im);
            end
            default: ;
        endcase
    end

    assign sts.idle = (state_reg == ST_IDLE);
    assign sts.done = (state_reg == ST_DONE) && unload;
    assign count    = count_reg;

endmodule

`default_nettype wire

// ===== design/etf_checker.sv =====
// Port-level checker for the escape-time fractal pixel block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module etf_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_valid,
    input wire       s_ready,
    input wire       m_valid,
    input wire       m_ready,
    input wire [11:0] m_iteration_count,
    input wire [7:0] m_red,
    input wire [7:0] m_green,
    input wire [7:0] m_blue
);

    // Hold a stalled result steady
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_iteration_count) &&
        $stable(m_red) && $stable(m_green) && $stable(m_blue))
        else $error("result changed while stalled");

    // Drop ready after a point is taken: one point in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after an input transfer");

    // A new result only appears at the end of a busy period
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while the engine was idle");

    // Counts that wrap the palette map to one of the two entry-zero colors
    a_entry_zero_color: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_iteration_count[3:0] == 4'd0) |->
        (m_red == 8'd66 && m_green == 8'd30 && m_blue == 8'd15) ||
        (m_red == 8'd0 && m_green == 8'd0 && m_blue == 8'd0))
        else $error("wrong color for palette entry zero");

endmodule

bind escape_time_fractal_pixel etf_checker u_etf_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_iteration_count (m_iteration_count),
    .m_red             (m_red),
    .m_green           (m_green),
    .m_blue            (m_blue)
);

`default_nettype wire

// ===== tb/sv/fractal_pixel_checker.sv =====
// Checker for the escape-time fractal pixel block: predicts each pixel and compares results.
`timescale 1ns / 1ps

module fractal_pixel_checker #(
    parameter int FRAC = 27
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [etf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [etf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic                                s_valid,
    input  wire logic                                s_ready,
    input  wire logic signed [etf_pkg::COORD_W-1:0]  s_point_re,
    input  wire logic signed [etf_pkg::COORD_W-1:0]  s_point_im,
    input  wire logic                                m_valid,
    input  wire logic                                m_ready,
    input  wire logic [etf_pkg::OUT_COUNT_W-1:0]     m_iteration_count,
    input  wire logic [etf_pkg::CHAN_W-1:0]          m_red,
    input  wire logic [etf_pkg::CHAN_W-1:0]          m_green,
    input  wire logic [etf_pkg::CHAN_W-1:0]          m_blue,
    output int                                       failures,
    output int                                       pending
);

    typedef struct packed {
        logic [etf_pkg::OUT_COUNT_W-1:0] count;
        logic [etf_pkg::CHAN_W-1:0]      red;
        logic [etf_pkg::CHAN_W-1:0]      green;
        logic [etf_pkg::CHAN_W-1:0]      blue;
    } pixel_t;

    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483647 - 64'sd1;
    localparam longint BOX    = 64'sd2 <<< FRAC;

    // Shadow copy of the block's registers
    logic [etf_pkg::MAX_ITER_W-1:0] iter_limit;
    logic                           julia_sel;
    logic signed [31:0]             jconst_re;
    logic signed [31:0]             jconst_im;

    pixel_t expected_pixels [$];

    function automatic longint clamp32(input longint x);
        if (x > S32_HI) return S32_HI;
        if (x < S32_LO) return S32_LO;
        return x;
    endfunction

    // One z = z^2 + c step with floor scaling and 32-bit saturation
    function automatic void square_add(inout longint zr, inout longint zi,
                                       input longint cr, input longint ci);
        longint re_next;
        longint im_next;
        re_next = ((zr * zr) >>> FRAC) - ((zi * zi) >>> FRAC) + cr;
        im_next = ((zr * zi) >>> (FRAC - 1)) + ci;
        zr = clamp32(re_next);
        zi = clamp32(im_next);
    endfunction

    function automatic logic [23:0] palette_color(input logic [3:0] idx);
        case (idx)
            4'd0:    return {8'd66, 8'd30, 8'd15};
            4'd1:    return {8'd25, 8'd7, 8'd26};
            4'd2:    return {8'd9, 8'd1, 8'd47};
            4'd3:    return {8'd4, 8'd4, 8'd73};
            4'd4:    return {8'd0, 8'd7, 8'd100};
            4'd5:    return {8'd12, 8'd44, 8'd138};
            4'd6:    return {8'd24, 8'd82, 8'd177};
            4'd7:    return {8'd57, 8'd125, 8'd209};
            4'd8:    return {8'd134, 8'd181, 8'd229};
            4'd9:    return {8'd211, 8'd236, 8'd248};
            4'd10:   return {8'd241, 8'd233, 8'd191};
            4'd11:   return {8'd248, 8'd201, 8'd95};
            4'd12:   return {8'd255, 8'd170, 8'd0};
            4'd13:   return {8'd204, 8'd128, 8'd0};
            4'd14:   return {8'd153, 8'd87, 8'd0};
            default: return {8'd106, 8'd52, 8'd3};
        endcase
    endfunction

    // Iterate one point under the current settings and color the count
    function automatic pixel_t predict_pixel(input logic signed [31:0] pre,
                                             input logic signed [31:0] pim);
        longint      zr;
        longint      zi;
        longint      cr;
        longint      ci;
        int unsigned steps;
        logic [23:0] rgb;
        pixel_t      px;
        if (julia_sel) begin
            zr = pre;
            zi = pim;
            cr = jconst_re;
            ci = jconst_im;
        end else begin
            zr = 0;
            zi = 0;
            cr = pre;
            ci = pim;
        end
        square_add(zr, zi, cr, ci);
        steps = 0;
        while (zr <= BOX && zr >= -BOX && zi <= BOX && zi >= -BOX && steps < iter_limit) begin
            square_add(zr, zi, cr, ci);
            steps++;
        end
        rgb = palette_color(steps[3:0]);
        // Julia mode paints the wrap-around entry black
        if (julia_sel && steps[3:0] == 4'd0)
            rgb = '0;
        px.count = steps[etf_pkg::OUT_COUNT_W-1:0];
        {px.red, px.green, px.blue} = rgb;
        return px;
    endfunction

    always @(posedge aclk) begin
        pixel_t want;
        if (!aresetn) begin
            iter_limit = etf_pkg::MAX_ITER_RESET;
            julia_sel  = 1'b0;
            jconst_re  = '0;
            jconst_im  = '0;
            expected_pixels.delete();
            failures   = 0;
        end else begin
            // Track register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    etf_pkg::CFG_MAX_ITER:  iter_limit = cfg_wdata[etf_pkg::MAX_ITER_W-1:0];
                    etf_pkg::CFG_JULIA:     julia_sel  = cfg_wdata[0];
                    etf_pkg::CFG_JCONST_RE: jconst_re  = cfg_wdata;
                    etf_pkg::CFG_JCONST_IM: jconst_im  = cfg_wdata;
                    default: ;
                endcase
            end
            // Compare a result transfer against the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result transfer with no pixel outstanding: count %0d rgb %0d,%0d,%0d",
                           m_iteration_count, m_red, m_green, m_blue);
                    failures++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_iteration_count !== want.count) begin
                        $error("iteration_count: expected %0d, got %0d",
                               want.count, m_iteration_count);
                        failures++;
                    end
                    if (m_red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, m_red);
                        failures++;
                    end
                    if (m_green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, m_green);
                        failures++;
                    end
                    if (m_blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, m_blue);
                        failures++;
                    end
                end
            end
            // Predict each accepted point
            if (s_valid && s_ready)
                expected_pixels.push_back(predict_pixel(s_point_re, s_point_im));
        end
        pending = expected_pixels.size();
    end

endmodule

// ===== tb/sv/escape_time_fractal_pixel_tb.sv =====
// Testbench top for the escape-time fractal pixel block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module escape_time_fractal_pixel_tb;

    localparam int     ONE             = 1 << 27;
    localparam int     TWO             = 2 << 27;
    localparam int     SPAN            = 301989888;   // 2.25 in fixed point
    localparam int     RAND_PHASES     = 10;
    localparam int     PHASE_ITEMS     = 133;
    localparam int     HOLD_OFF_CYCLES = 500;
    localparam longint TIMEOUT_NS      = 64'd50_000_000;

    logic                                 aclk      = 1'b0;
    logic                                 aresetn   = 1'b0;
    logic                                 cfg_wr_en = 1'b0;
    logic [etf_pkg::CFG_INDEX_W-1:0]      cfg_index = '0;
    logic [etf_pkg::CFG_DATA_W-1:0]       cfg_wdata = '0;
    logic                                 s_valid   = 1'b0;
    logic                                 s_ready;
    logic signed [etf_pkg::COORD_W-1:0]   s_point_re = '0;
    logic signed [etf_pkg::COORD_W-1:0]   s_point_im = '0;
    logic                                 m_valid;
    logic                                 m_ready   = 1'b0;
    logic [etf_pkg::OUT_COUNT_W-1:0]      m_iteration_count;
    logic [etf_pkg::CHAN_W-1:0]           m_red;
    logic [etf_pkg::CHAN_W-1:0]           m_green;
    logic [etf_pkg::CHAN_W-1:0]           m_blue;

    int failures;
    int pending;
    int send_idle_pct  = 30;
    int stall_pct      = 30;
    bit hold_off_req   = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    escape_time_fractal_pixel u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_point_re        (s_point_re),
        .s_point_im        (s_point_im),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_iteration_count (m_iteration_count),
        .m_red             (m_red),
        .m_green           (m_green),
        .m_blue            (m_blue)
    );

    fractal_pixel_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_point_re        (s_point_re),
        .s_point_im        (s_point_im),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_iteration_count (m_iteration_count),
        .m_red             (m_red),
        .m_green           (m_green),
        .m_blue            (m_blue),
        .failures          (failures),
        .pending           (pending)
    );

    // Mostly short gaps, now and then a long one
    function automatic int gap_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Mostly points near the set, some anywhere, some hugging the box edge
    function automatic int random_coord();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return int'($urandom_range(0, 2 * SPAN)) - SPAN;
        if (pick < 85)
            return $urandom;
        return ($urandom_range(0, 1) ? TWO : -TWO) + int'($urandom_range(0, 8)) - 4;
    endfunction

    task automatic send_point(input int re, input int im);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? gap_length() : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_point_re <= re;
        s_point_im <= im;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [etf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [etf_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
    endtask

    task automatic program_regs(input logic [31:0] iters, input logic [31:0] mode,
                                input logic [31:0] c_re, input logic [31:0] c_im);
        write_reg(etf_pkg::CFG_MAX_ITER, iters);
        write_reg(etf_pkg::CFG_JULIA, mode);
        write_reg(etf_pkg::CFG_JCONST_RE, c_re);
        write_reg(etf_pkg::CFG_JCONST_IM, c_im);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Drop valid, wait for every predicted pixel, then let the output register clear
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int quiet_left;
        quiet_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                quiet_left   = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end else if (quiet_left == 0 && $urandom_range(0, 99) < stall_pct) begin
                quiet_left = gap_length();
            end
            if (quiet_left > 0) begin
                m_ready <= 1'b0;
                quiet_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [31:0] iters;
        logic [31:0] c_re;
        logic [31:0] c_im;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: Mandelbrot, limit 50
        send_point(0, 0);
        send_point(-ONE, 0);
        send_point(TWO, 0);
        send_point(-TWO, 0);
        send_point(TWO + 1, 0);
        send_point(0, TWO);
        send_point(0, -TWO);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_point(ONE / 4, 0);
        send_point(-100663296, 13421773);
        settle();

        // Zero limit, upper data bits ignored
        program_regs(32'hFFFF_F000, 32'h0, 32'h0, 32'h0);
        send_point(0, 0);
        send_point(3 * ONE, 0);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
        settle();

        // Julia with a classic constant; only bit 0 of the mode counts
        program_regs(32'd50, 32'h0000_0003, -107374182, 20937965);
        send_point(0, 0);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(40265318, -26843546);
        settle();

        // Julia with extreme constants
        program_regs(32'd10, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(0, 0);
        settle();

        // Largest limit, mode word with bit 0 clear
        program_regs(32'hABCD_0FFF, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(0, 0);
        send_point(-ONE, 0);
        settle();

        // Random phases with random settings
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 4)
                iters = 32'd0;
            else if (p % 3 == 0)
                iters = $urandom_range(65, 127);
            else
                iters = $urandom_range(1, 64);
            iters[31:12] = 20'($urandom);
            c_re = ($urandom_range(0, 3) == 0) ? $urandom
                 : int'($urandom_range(0, 2 * ONE)) - ONE;
            c_im = ($urandom_range(0, 3) == 0) ? $urandom
                 : int'($urandom_range(0, 2 * ONE)) - ONE;
            program_regs(iters, $urandom, c_re, c_im);
            if (p == 2) begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end else begin
                send_idle_pct = $urandom_range(10, 50);
                stall_pct     = $urandom_range(10, 50);
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 5 && i == 20)
                    hold_off_req = 1'b1;
                send_point(random_coord(), random_coord());
            end
            settle();
        end

        repeat (20) @(negedge aclk);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Hard stop if the block hangs
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
